// File: design/gift_wrap_convex_hull_unit_defines.svh
// assertion macros for the convex hull unit
`ifndef GIFT_WRAP_CONVEX_HULL_UNIT_DEFINES_SVH
`define GIFT_WRAP_CONVEX_HULL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold in the same cycle as the trigger
`define GWCH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// condition must hold in the cycle after the trigger
`define GWCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define GWCH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GWCH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/gwch_pkg.sv
// shared constants for the convex hull unit
`default_nettype none

package gwch_pkg;

   // width of every coordinate port
   localparam int FIELD_BITS = 32;

endpackage

`default_nettype wire

// File: design/gift_wrap_convex_hull_unit.sv
// Gift-wrapping convex hull unit in the xy plane over a stored point set.
//
// Input channel (req_*): one point per transaction, x/y/z in signed Q16.16.
// A point with req_set_end high is stored and then starts the hull run.
// Points past MAX_POINTS are dropped; set_end still starts the run.
// Loading accepts one point per cycle while idle; req_ready is low during a run.
// Result channel (rsp_*): one hull vertex per transaction, then the closing
// vertex with rsp_final_vertex high (rsp_no_closure high if the vertex bound
// was hit before the ring closed).
// For n stored points the start search scans all n points from the point memory;
// each hull vertex then takes a scan of the points, each read in turn from the
// point memory and handled by a multiply step, then a compare and update step;
// the closing vertex follows.
// The output register lets the next run's loading start while the closing
// vertex waits. When rsp_ready is low the run stalls at the emit step.
// Reset clears the point count, the run state and the output valid; the
// point memory is not cleared, only entries loaded in the current set are read.
`default_nettype none

`include "gift_wrap_convex_hull_unit_defines.svh"

module gift_wrap_convex_hull_unit #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  signed [gwch_pkg::FIELD_BITS-1:0] req_px,
   input  wire  signed [gwch_pkg::FIELD_BITS-1:0] req_py,
   input  wire  signed [gwch_pkg::FIELD_BITS-1:0] req_pz,
   input  wire                                    req_set_end,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic signed [gwch_pkg::FIELD_BITS-1:0] rsp_hx,
   output logic signed [gwch_pkg::FIELD_BITS-1:0] rsp_hy,
   output logic signed [gwch_pkg::FIELD_BITS-1:0] rsp_hz,
   output logic                                   rsp_final_vertex,
   output logic                                   rsp_no_closure
);

   localparam int FB = gwch_pkg::FIELD_BITS;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   // sequencer codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MIN_WAIT = 4'd1;
   localparam logic [3:0] ST_MIN_SCAN = 4'd2;
   localparam logic [3:0] ST_V_WAIT   = 4'd3;
   localparam logic [3:0] ST_V_FIRST  = 4'd4;
   localparam logic [3:0] ST_V_MUL    = 4'd5;
   localparam logic [3:0] ST_V_CMP    = 4'd6;
   localparam logic [3:0] ST_V_EMIT   = 4'd7;
   localparam logic [3:0] ST_F_EMIT   = 4'd8;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } vtx_type;

   // point memory
   vtx_type point_mem [MAX_POINTS];
   vtx_type mem_rd_ff;
   vtx_type wr_vtx;
   logic    wr_en;

   // control state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] vc_ff, vc_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath state
   logic [CW-1:0]        j_ff, j_in;
   vtx_type              cur_ff, cur_in;
   vtx_type              cand_ff, cand_in;
   vtx_type              first_ff, first_in;
   vtx_type              pj_ff, pj_in;
   logic                 same_ff, same_in;
   logic                 nc_pend_ff, nc_pend_in;
   logic signed [PW-1:0] prod_b_ff, prod_b_in;
   logic signed [PW-1:0] prod_c_ff, prod_c_in;
   logic signed [FB-1:0] out_x_ff, out_x_in;
   logic signed [FB-1:0] out_y_ff, out_y_in;
   logic signed [FB-1:0] out_z_ff, out_z_in;
   logic                 out_fin_ff, out_fin_in;
   logic                 out_nc_ff, out_nc_in;

   // cross product operands
   logic signed [DW-1:0] d_bx, d_by, d_cx, d_cy;
   logic                 slot_free;
   logic                 store_room;

   assign req_ready  = (state_ff == ST_IDLE);
   assign store_room = (count_ff < CW'(MAX_POINTS));
   assign wr_en      = req_valid && req_ready && store_room;
   assign wr_vtx.x   = req_px[COORD_BITS-1:0];
   assign wr_vtx.y   = req_py[COORD_BITS-1:0];
   assign wr_vtx.z   = req_pz[COORD_BITS-1:0];
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // differences against the current vertex: b is the candidate, c the scanned point
   assign d_bx = DW'(cand_ff.x) - DW'(cur_ff.x);
   assign d_by = DW'(cand_ff.y) - DW'(cur_ff.y);
   assign d_cx = DW'(mem_rd_ff.x) - DW'(cur_ff.x);
   assign d_cy = DW'(mem_rd_ff.y) - DW'(cur_ff.y);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[count_ff[AW-1:0]] <= wr_vtx;
      end
      mem_rd_ff <= point_mem[addr_ff];
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      vc_in        = vc_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      cand_in      = cand_ff;
      first_in     = first_ff;
      pj_in        = pj_ff;
      same_in      = same_ff;
      nc_pend_in   = nc_pend_ff;
      prod_b_in    = prod_b_ff;
      prod_c_in    = prod_c_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_fin_in   = out_fin_ff;
      out_nc_in    = out_nc_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (store_room) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_set_end) begin
                  addr_in  = '0;
                  state_in = ST_MIN_WAIT;
               end
            end
         end
         ST_MIN_WAIT: begin
            addr_in  = addr_ff + AW'(1);
            j_in     = '0;
            state_in = ST_MIN_SCAN;
         end
         // leftmost point, first one wins on ties
         ST_MIN_SCAN: begin
            addr_in = addr_ff + AW'(1);
            j_in    = j_ff + CW'(1);
            if (j_ff == '0 || mem_rd_ff.x < cur_ff.x) begin
               cur_in = mem_rd_ff;
            end
            if (j_ff == count_ff - CW'(1)) begin
               first_in = cur_in;
               vc_in    = '0;
               addr_in  = '0;
               state_in = ST_V_WAIT;
            end
         end
         ST_V_WAIT: begin
            addr_in  = addr_ff + AW'(1);
            state_in = ST_V_FIRST;
         end
         ST_V_FIRST: begin
            addr_in  = addr_ff + AW'(1);
            cand_in  = mem_rd_ff;
            j_in     = CW'(1);
            state_in = (count_ff == CW'(1)) ? ST_V_EMIT : ST_V_MUL;
         end
         // cross product terms, registered
         ST_V_MUL: begin
            pj_in     = mem_rd_ff;
            same_in   = (cand_ff == cur_ff);
            prod_b_in = d_bx * d_cy;
            prod_c_in = d_cx * d_by;
            state_in  = ST_V_CMP;
         end
         // left turn or degenerate candidate replaces it; next point read meanwhile
         ST_V_CMP: begin
            addr_in = addr_ff + AW'(1);
            if (same_ff || prod_b_ff > prod_c_ff) begin
               cand_in = pj_ff;
            end
            j_in     = j_ff + CW'(1);
            state_in = (j_ff == count_ff - CW'(1)) ? ST_V_EMIT : ST_V_MUL;
         end
         ST_V_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = FB'(cur_ff.x);
               out_y_in     = FB'(cur_ff.y);
               out_z_in     = FB'(cur_ff.z);
               out_fin_in   = 1'b0;
               out_nc_in    = 1'b0;
               vc_in        = vc_ff + CW'(1);
               cur_in       = cand_ff;
               if (cand_ff == first_ff) begin
                  nc_pend_in = 1'b0;
                  state_in   = ST_F_EMIT;
               end else if (vc_ff + CW'(1) == CW'(MAX_POINTS)) begin
                  nc_pend_in = 1'b1;
                  state_in   = ST_F_EMIT;
               end else begin
                  addr_in  = '0;
                  state_in = ST_V_WAIT;
               end
            end
         end
         ST_F_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = FB'(cand_ff.x);
               out_y_in     = FB'(cand_ff.y);
               out_z_in     = FB'(cand_ff.z);
               out_fin_in   = 1'b1;
               out_nc_in    = nc_pend_ff;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         vc_ff        <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vc_ff        <= vc_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      j_ff       <= j_in;
      cur_ff     <= cur_in;
      cand_ff    <= cand_in;
      first_ff   <= first_in;
      pj_ff      <= pj_in;
      same_ff    <= same_in;
      nc_pend_ff <= nc_pend_in;
      prod_b_ff  <= prod_b_in;
      prod_c_ff  <= prod_c_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_z_ff   <= out_z_in;
      out_fin_ff <= out_fin_in;
      out_nc_ff  <= out_nc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hx           = out_x_ff;
   assign rsp_hy           = out_y_ff;
   assign rsp_hz           = out_z_ff;
   assign rsp_final_vertex = out_fin_ff;
   assign rsp_no_closure   = out_nc_ff;

   // checks
   `GWCH_ASSERT_IMPLY(a_nc_only_final, clock, reset, rsp_valid && rsp_no_closure, rsp_final_vertex)
   `GWCH_ASSERT_IMPLY(a_vc_bound, clock, reset, state_ff != ST_IDLE, vc_ff <= CW'(MAX_POINTS))
   `GWCH_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_POINTS))
   `GWCH_ASSERT_NEXT(a_final_to_idle, clock, reset, state_ff == ST_F_EMIT && slot_free, state_ff == ST_IDLE && count_ff == '0 && rsp_valid_ff && out_fin_ff)

endmodule

`default_nettype wire
